// ===== design/sphere_triangle_subdivide_unit_macros.svh =====
// Assertion helpers for the subdivider top-level RTL.
`ifndef SPHERE_TRIANGLE_SUBDIVIDE_UNIT_MACROS_SVH
`define SPHERE_TRIANGLE_SUBDIVIDE_UNIT_MACROS_SVH

// ante holds now -> cons holds in the same cycle
`define STSD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// ante holds now -> cons holds in the next cycle
`define STSD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/stsd_pkg.sv =====
`default_nettype none
package stsd_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int SQRT_STEPS = 33;  // root of a 66-bit sum is below 2^33
   localparam int DIV_STEPS  = 31;  // quotient never exceeds the 31-bit radius
   localparam int PROJ_LAT   = 3 + SQRT_STEPS + DIV_STEPS + 1;

   localparam logic [30:0] RADIUS_RESET = 31'(1) << FRAC_BITS;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vec_type;

   typedef enum logic [1:0] {
      CHILD_A   = 2'd0,
      CHILD_B   = 2'd1,
      CHILD_C   = 2'd2,
      CHILD_MID = 2'd3
   } child_type;

endpackage
`default_nettype wire

// ===== design/stsd_proj.sv =====
`default_nettype none
// Projects the edge sum P+Q onto the sphere of the given radius.
// Stages: sum/magnitude, squares and radius products, square sum,
// one root bit per stage, one quotient bit per stage, round and sign.
module stsd_proj
   import stsd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire vec_type     p,
   input  wire vec_type     q,
   input  wire logic [30:0] radius,
   output vec_type          n,
   output logic             degen
);

   logic                    s1_sign_ff [3];
   logic [32:0]             s1_mag_ff  [3];
   logic                    s1_sign_in [3];
   logic [32:0]             s1_mag_in  [3];

   logic [65:0]             s2_sq_ff   [3];
   logic [63:0]             s2_num_ff  [3];
   logic                    s2_sign_ff [3];
   logic [65:0]             s2_sq_in   [3];
   logic [63:0]             s2_num_in  [3];

   logic [65:0]             s3_sum_ff;
   logic [63:0]             s3_num_ff  [3];
   logic                    s3_sign_ff [3];
   logic [65:0]             s3_sum_in;

   logic [33:0]             sq_rem_ff  [SQRT_STEPS];
   logic [32:0]             sq_root_ff [SQRT_STEPS];
   logic [65:0]             sq_rad_ff  [SQRT_STEPS];
   logic [63:0]             sq_num_ff  [SQRT_STEPS][3];
   logic                    sq_sign_ff [SQRT_STEPS][3];
   logic [33:0]             sq_rem_in  [SQRT_STEPS];
   logic [32:0]             sq_root_in [SQRT_STEPS];
   logic [65:0]             sq_rad_in  [SQRT_STEPS];
   logic [63:0]             sq_num_in  [SQRT_STEPS][3];
   logic                    sq_sign_in [SQRT_STEPS][3];

   logic [32:0]             dv_rem_ff  [DIV_STEPS][3];
   logic [30:0]             dv_quo_ff  [DIV_STEPS][3];
   logic [30:0]             dv_low_ff  [DIV_STEPS][3];
   logic                    dv_sign_ff [DIV_STEPS][3];
   logic [32:0]             dv_root_ff [DIV_STEPS];
   logic [32:0]             dv_rem_in  [DIV_STEPS][3];
   logic [30:0]             dv_quo_in  [DIV_STEPS][3];
   logic [30:0]             dv_low_in  [DIV_STEPS][3];
   logic                    dv_sign_in [DIV_STEPS][3];
   logic [32:0]             dv_root_in [DIV_STEPS];

   logic [31:0]             n_ff [3];
   logic [31:0]             n_in [3];
   logic                    degen_ff;
   logic                    degen_in;

   // sum and magnitude
   always_comb begin
      logic [32:0] s [3];
      s[0] = {p.x[31], p.x} + {q.x[31], q.x};
      s[1] = {p.y[31], p.y} + {q.y[31], q.y};
      s[2] = {p.z[31], p.z} + {q.z[31], q.z};
      for (int c = 0; c < 3; c++) begin
         s1_sign_in[c] = s[c][32];
         s1_mag_in[c]  = s[c][32] ? 33'(-s[c]) : s[c];
      end
   end

   // squares and radius products
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s2_sq_in[c]  = {33'd0, s1_mag_ff[c]} * {33'd0, s1_mag_ff[c]};
         s2_num_in[c] = {31'd0, s1_mag_ff[c]} * {33'd0, radius};
      end
   end

   assign s3_sum_in = s2_sq_ff[0] + s2_sq_ff[1] + s2_sq_ff[2];

   // restoring square root, one result bit per stage
   always_comb begin
      logic [33:0] prem;
      logic [32:0] proot;
      logic [65:0] prad;
      logic [35:0] cur;
      logic [35:0] trial;
      for (int i = 0; i < SQRT_STEPS; i++) begin
         if (i == 0) begin
            prem  = '0;
            proot = '0;
            prad  = s3_sum_ff;
            for (int c = 0; c < 3; c++) begin
               sq_num_in[i][c]  = s3_num_ff[c];
               sq_sign_in[i][c] = s3_sign_ff[c];
            end
         end else begin
            prem  = sq_rem_ff[i-1];
            proot = sq_root_ff[i-1];
            prad  = sq_rad_ff[i-1];
            for (int c = 0; c < 3; c++) begin
               sq_num_in[i][c]  = sq_num_ff[i-1][c];
               sq_sign_in[i][c] = sq_sign_ff[i-1][c];
            end
         end
         cur   = {prem, prad[65:64]};
         trial = {1'b0, proot, 2'b01};
         if (cur >= trial) begin
            sq_rem_in[i]  = 34'(cur - trial);
            sq_root_in[i] = {proot[31:0], 1'b1};
         end else begin
            sq_rem_in[i]  = cur[33:0];
            sq_root_in[i] = {proot[31:0], 1'b0};
         end
         sq_rad_in[i] = {prad[63:0], 2'b00};
      end
   end

   // restoring division by the root, one quotient bit per stage
   always_comb begin
      logic [32:0] prem;
      logic [30:0] pquo;
      logic [30:0] plow;
      logic [33:0] t;
      for (int j = 0; j < DIV_STEPS; j++) begin
         dv_root_in[j] = (j == 0) ? sq_root_ff[SQRT_STEPS-1] : dv_root_ff[j-1];
         for (int c = 0; c < 3; c++) begin
            if (j == 0) begin
               prem = sq_num_ff[SQRT_STEPS-1][c][63:31];
               pquo = '0;
               plow = sq_num_ff[SQRT_STEPS-1][c][30:0];
               dv_sign_in[j][c] = sq_sign_ff[SQRT_STEPS-1][c];
            end else begin
               prem = dv_rem_ff[j-1][c];
               pquo = dv_quo_ff[j-1][c];
               plow = dv_low_ff[j-1][c];
               dv_sign_in[j][c] = dv_sign_ff[j-1][c];
            end
            t = {prem, plow[30]};
            if (t >= {1'b0, dv_root_in[j]}) begin
               dv_rem_in[j][c] = 33'(t - {1'b0, dv_root_in[j]});
               dv_quo_in[j][c] = {pquo[29:0], 1'b1};
            end else begin
               dv_rem_in[j][c] = t[32:0];
               dv_quo_in[j][c] = {pquo[29:0], 1'b0};
            end
            dv_low_in[j][c] = {plow[29:0], 1'b0};
         end
      end
   end

   // round half away from zero, restore sign
   always_comb begin
      logic [32:0] root;
      logic        up;
      logic [31:0] mag;
      root     = dv_root_ff[DIV_STEPS-1];
      degen_in = (root == '0);
      for (int c = 0; c < 3; c++) begin
         up  = {dv_rem_ff[DIV_STEPS-1][c], 1'b0} >= {1'b0, root};
         mag = {1'b0, dv_quo_ff[DIV_STEPS-1][c]} + {31'd0, up};
         if (degen_in) begin
            n_in[c] = '0;
         end else begin
            n_in[c] = dv_sign_ff[DIV_STEPS-1][c] ? 32'(-mag) : mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sign_ff <= s1_sign_in;
         s1_mag_ff  <= s1_mag_in;
         s2_sq_ff   <= s2_sq_in;
         s2_num_ff  <= s2_num_in;
         s2_sign_ff <= s1_sign_ff;
         s3_sum_ff  <= s3_sum_in;
         s3_num_ff  <= s2_num_ff;
         s3_sign_ff <= s2_sign_ff;
         sq_rem_ff  <= sq_rem_in;
         sq_root_ff <= sq_root_in;
         sq_rad_ff  <= sq_rad_in;
         sq_num_ff  <= sq_num_in;
         sq_sign_ff <= sq_sign_in;
         dv_rem_ff  <= dv_rem_in;
         dv_quo_ff  <= dv_quo_in;
         dv_low_ff  <= dv_low_in;
         dv_sign_ff <= dv_sign_in;
         dv_root_ff <= dv_root_in;
         n_ff       <= n_in;
         degen_ff   <= degen_in;
      end
   end

   assign n.x   = n_ff[0];
   assign n.y   = n_ff[1];
   assign n.z   = n_ff[2];
   assign degen = degen_ff;

endmodule
`default_nettype wire

// ===== design/sphere_triangle_subdivide_unit.sv =====
`default_nettype none
// Channel  Handshake          Carries
// req      req_valid/stall    one triangle A, B, C
// rsp      rsp_valid/stall    one child triangle, index, degenerate, last
// csr      csr_valid/ready    radius, unsigned Q15.16
//
// Each triangle gives four words, one per cycle while rsp is not stalled, so the
// output serializer sets the triangle rate; the next loads as the last word goes.
// A triangle passes the taking edge, the edge projection stages and then the
// serializer load before its first word is valid.
// Reset clears valid bits, the serializer and sets radius to 1.0.
// rsp stalls or unsent words freeze the pipeline once its last stage is full.
module sphere_triangle_subdivide_unit
   import stsd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_ax,
   input  wire logic signed [31:0] req_ay,
   input  wire logic signed [31:0] req_az,
   input  wire logic signed [31:0] req_bx,
   input  wire logic signed [31:0] req_by_coord,
   input  wire logic signed [31:0] req_bz,
   input  wire logic signed [31:0] req_cx,
   input  wire logic signed [31:0] req_cy,
   input  wire logic signed [31:0] req_cz,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_p0x,
   output logic signed [31:0]      rsp_p0y,
   output logic signed [31:0]      rsp_p0z,
   output logic signed [31:0]      rsp_p1x,
   output logic signed [31:0]      rsp_p1y,
   output logic signed [31:0]      rsp_p1z,
   output logic signed [31:0]      rsp_p2x,
   output logic signed [31:0]      rsp_p2y,
   output logic signed [31:0]      rsp_p2z,
   output logic [1:0]              rsp_sub_index,
   output logic                    rsp_degenerate,
   output logic                    rsp_last,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [30:0]        csr_radius
);

`include "sphere_triangle_subdivide_unit_macros.svh"

   logic [30:0]     radius_ff;
   logic [PROJ_LAT-1:0] vld_ff;
   vec_type         va_ff [PROJ_LAT];
   vec_type         vb_ff [PROJ_LAT];
   vec_type         vc_ff [PROJ_LAT];
   vec_type         in_a, in_b, in_c;
   vec_type         nab, nbc, nca;
   logic            dab, dbc, dca;
   logic            adv;
   logic            out_take;
   logic            rsp_fire;

   logic            ser_vld_ff;
   child_type       ser_cnt_ff;
   vec_type         ser_a_ff, ser_b_ff, ser_c_ff;
   vec_type         ser_ab_ff, ser_bc_ff, ser_ca_ff;
   logic            ser_dab_ff, ser_dbc_ff, ser_dca_ff;
   vec_type         o0, o1, o2;
   logic            odeg;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         radius_ff <= csr_radius;
      end
   end

   assign rsp_fire  = ser_vld_ff && !rsp_stall;
   assign out_take  = !ser_vld_ff || (rsp_fire && ser_cnt_ff == CHILD_MID);
   assign adv       = !vld_ff[PROJ_LAT-1] || out_take;
   assign req_stall = !adv;

   assign in_a = '{x: req_ax, y: req_ay,       z: req_az};
   assign in_b = '{x: req_bx, y: req_by_coord, z: req_bz};
   assign in_c = '{x: req_cx, y: req_cy,       z: req_cz};

   stsd_proj u_ab (.clock, .en(adv), .p(in_a), .q(in_b), .radius(radius_ff),
                   .n(nab), .degen(dab));
   stsd_proj u_bc (.clock, .en(adv), .p(in_b), .q(in_c), .radius(radius_ff),
                   .n(nbc), .degen(dbc));
   stsd_proj u_ca (.clock, .en(adv), .p(in_c), .q(in_a), .radius(radius_ff),
                   .n(nca), .degen(dca));

   // valid bits and original vertices ride alongside the projection stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PROJ_LAT-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         va_ff[0] <= in_a;
         vb_ff[0] <= in_b;
         vc_ff[0] <= in_c;
         for (int i = 1; i < PROJ_LAT; i++) begin
            va_ff[i] <= va_ff[i-1];
            vb_ff[i] <= vb_ff[i-1];
            vc_ff[i] <= vc_ff[i-1];
         end
      end
   end

   // serializer: holds one finished triangle, sends four words
   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
         ser_cnt_ff <= CHILD_A;
      end else if (out_take && vld_ff[PROJ_LAT-1]) begin
         ser_vld_ff <= 1'b1;
         ser_cnt_ff <= CHILD_A;
      end else if (out_take) begin
         ser_vld_ff <= 1'b0;
         ser_cnt_ff <= CHILD_A;
      end else if (rsp_fire) begin
         ser_cnt_ff <= child_type'(ser_cnt_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (out_take && vld_ff[PROJ_LAT-1]) begin
         ser_a_ff   <= va_ff[PROJ_LAT-1];
         ser_b_ff   <= vb_ff[PROJ_LAT-1];
         ser_c_ff   <= vc_ff[PROJ_LAT-1];
         ser_ab_ff  <= nab;
         ser_bc_ff  <= nbc;
         ser_ca_ff  <= nca;
         ser_dab_ff <= dab;
         ser_dbc_ff <= dbc;
         ser_dca_ff <= dca;
      end
   end

   always_comb begin
      unique case (ser_cnt_ff)
         CHILD_A: begin
            o0 = ser_a_ff;  o1 = ser_ca_ff; o2 = ser_ab_ff;
            odeg = ser_dca_ff || ser_dab_ff;
         end
         CHILD_B: begin
            o0 = ser_b_ff;  o1 = ser_ab_ff; o2 = ser_bc_ff;
            odeg = ser_dab_ff || ser_dbc_ff;
         end
         CHILD_C: begin
            o0 = ser_c_ff;  o1 = ser_bc_ff; o2 = ser_ca_ff;
            odeg = ser_dbc_ff || ser_dca_ff;
         end
         default: begin
            o0 = ser_bc_ff; o1 = ser_ab_ff; o2 = ser_ca_ff;
            odeg = ser_dab_ff || ser_dbc_ff || ser_dca_ff;
         end
      endcase
   end

   assign rsp_valid      = ser_vld_ff;
   assign rsp_p0x        = o0.x;
   assign rsp_p0y        = o0.y;
   assign rsp_p0z        = o0.z;
   assign rsp_p1x        = o1.x;
   assign rsp_p1y        = o1.y;
   assign rsp_p1z        = o1.z;
   assign rsp_p2x        = o2.x;
   assign rsp_p2y        = o2.y;
   assign rsp_p2z        = o2.z;
   assign rsp_sub_index  = ser_cnt_ff;
   assign rsp_degenerate = odeg;
   assign rsp_last       = (ser_cnt_ff == CHILD_MID);

   // input backs up only when a finished triangle waits on a busy serializer
   `STSD_ASSERT_NOW(a_stall_cause, req_stall, ser_vld_ff && vld_ff[PROJ_LAT-1],
      "req stalled without a full output side")
   // a non-final word that is taken moves on to the next child
   `STSD_ASSERT_NEXT(a_child_step, rsp_fire && !rsp_last,
      rsp_valid && rsp_sub_index == 2'($past(rsp_sub_index) + 2'd1),
      "child index did not advance")
   // final word taken with nothing behind it empties the serializer
   `STSD_ASSERT_NEXT(a_drain, rsp_fire && rsp_last && !vld_ff[PROJ_LAT-1], !rsp_valid,
      "serializer did not drain")
   // a new triangle always starts at the first child
   `STSD_ASSERT_NEXT(a_load_first, out_take && vld_ff[PROJ_LAT-1],
      rsp_valid && rsp_sub_index == 2'(CHILD_A),
      "new triangle did not start at child 0")

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb
   import stsd_pkg::*;
();

   localparam int LIMIT = 400000;

   typedef struct {
      vec_type a, b, c;
   } tri_type;

   typedef struct {
      vec_type   p0, p1, p2;
      child_type idx;
      logic      deg, last;
   } child_word_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [31:0] req_ax = 0, req_ay = 0, req_az = 0;
   logic signed [31:0] req_bx = 0, req_by_coord = 0, req_bz = 0;
   logic signed [31:0] req_cx = 0, req_cy = 0, req_cz = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_p0x, rsp_p0y, rsp_p0z, rsp_p1x, rsp_p1y, rsp_p1z;
   logic signed [31:0] rsp_p2x, rsp_p2y, rsp_p2z;
   logic [1:0] rsp_sub_index;
   logic rsp_degenerate, rsp_last;
   logic csr_valid = 0;
   logic csr_ready;
   logic [30:0] csr_radius = 0;

   sphere_triangle_subdivide_unit u_top (.*);

   always #6 clock = ~clock;

   tri_type        pending_tris[$];
   child_word_type expected_children[$];
   logic [30:0]    radius_now = RADIUS_RESET;
   int             snd_idle_pct = 0, rcv_idle_pct = 0;
   int             errors = 0;
   int             cycles = 0;
   logic           hold_start = 0, hold_used = 0;
   int             hold_left = 0;

   // project edge sum onto the sphere; returns 1 when the sum is the zero vector
   function automatic logic project_edge(input longint s[3], output vec_type n);
      bit [67:0] acc, sq;
      bit [33:0] root, t;
      bit [63:0] m[3], num, q, rem;
      logic [31:0] r[3];
      acc = 0;
      root = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = (s[i] < 0) ? 64'(-s[i]) : 64'(s[i]);
         acc += 68'(m[i]) * 68'(m[i]);
      end
      for (int b = 33; b >= 0; b--) begin
         t = root | (34'(1) << b);
         sq = 68'(t) * 68'(t);
         if (sq <= acc) root = t;
      end
      if (root == 0) begin
         n = '0;
         return 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
         num = m[i] * 64'(radius_now);
         q = num / 64'(root);
         rem = num % 64'(root);
         if (rem >= 64'(root) - rem) q++;
         r[i] = (s[i] < 0) ? 32'(-q) : 32'(q);
      end
      n.x = r[0];
      n.y = r[1];
      n.z = r[2];
      return 1'b0;
   endfunction

   function automatic void subdivide(input tri_type t);
      longint s[3];
      vec_type nab, nbc, nca;
      logic dab, dbc, dca;
      child_word_type w;
      s = '{longint'(t.a.x) + t.b.x, longint'(t.a.y) + t.b.y, longint'(t.a.z) + t.b.z};
      dab = project_edge(s, nab);
      s = '{longint'(t.b.x) + t.c.x, longint'(t.b.y) + t.c.y, longint'(t.b.z) + t.c.z};
      dbc = project_edge(s, nbc);
      s = '{longint'(t.c.x) + t.a.x, longint'(t.c.y) + t.a.y, longint'(t.c.z) + t.a.z};
      dca = project_edge(s, nca);
      w = '{t.a, nca, nab, CHILD_A, dca | dab, 1'b0};
      expected_children = {expected_children, w};
      w = '{t.b, nab, nbc, CHILD_B, dab | dbc, 1'b0};
      expected_children = {expected_children, w};
      w = '{t.c, nbc, nca, CHILD_C, dbc | dca, 1'b0};
      expected_children = {expected_children, w};
      w = '{nbc, nab, nca, CHILD_MID, dab | dbc | dca, 1'b1};
      expected_children = {expected_children, w};
   endfunction

   // sender: a word is taken when valid && !stall at this edge
   always @(posedge clock) begin
      tri_type t;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            t.a = '{req_ax, req_ay, req_az};
            t.b = '{req_bx, req_by_coord, req_bz};
            t.c = '{req_cx, req_cy, req_cz};
            subdivide(t);
         end
         if (!req_valid || !req_stall) begin
            if (pending_tris.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
               t = pending_tris.pop_front();
               {req_ax, req_ay, req_az} <= {t.a.x, t.a.y, t.a.z};
               {req_bx, req_by_coord, req_bz} <= {t.b.x, t.b.y, t.b.z};
               {req_cx, req_cy, req_cz} <= {t.c.x, t.c.y, t.c.z};
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with one long hold-off on request
   always @(posedge clock) begin
      if (hold_start && !hold_used) begin
         hold_used <= 1'b1;
         hold_left <= 500;
         rsp_stall <= 1'b1;
      end else begin
         if (hold_left > 0) hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1) || ($urandom_range(99) < rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      child_word_type e;
      logic [31:0] ef[12], af[12];
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_children.size() == 0) begin
            $display("%0t: unexpected word, p0=(%0d,%0d,%0d) idx=%0d", $realtime,
                     rsp_p0x, rsp_p0y, rsp_p0z, rsp_sub_index);
            errors++;
         end else begin
            e = expected_children.pop_front();
            ef = '{e.p0.x, e.p0.y, e.p0.z, e.p1.x, e.p1.y, e.p1.z,
                   e.p2.x, e.p2.y, e.p2.z, 32'(e.idx), 32'(e.deg), 32'(e.last)};
            af = '{rsp_p0x, rsp_p0y, rsp_p0z, rsp_p1x, rsp_p1y, rsp_p1z,
                   rsp_p2x, rsp_p2y, rsp_p2z, 32'(rsp_sub_index),
                   32'(rsp_degenerate), 32'(rsp_last)};
            for (int i = 0; i < 12; i++)
               if (ef[i] !== af[i]) begin
                  $display("%0t: field %0d mismatch, expected %0h actual %0h",
                           $realtime, i, ef[i], af[i]);
                  errors++;
               end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed(32'($urandom_range(131072))) - 65536;
         2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         default: return $signed($urandom) >>> $urandom_range(31);
      endcase
   endfunction

   function automatic vec_type rand_vec();
      vec_type v;
      v.x = rand_coord();
      v.y = rand_coord();
      v.z = rand_coord();
      return v;
   endfunction

   task automatic add_tri(input vec_type a, b, c);
      tri_type t;
      t.a = a;
      t.b = b;
      t.c = c;
      pending_tris = {pending_tris, t};
   endtask

   task automatic add_random(input int n);
      vec_type a, b, c;
      for (int i = 0; i < n; i++) begin
         a = rand_vec();
         b = rand_vec();
         c = rand_vec();
         // opposite vertices give a zero-length edge midpoint
         case ($urandom_range(7))
            0: b = '{-a.x, -a.y, -a.z};
            1: c = '{-b.x, -b.y, -b.z};
            2: c = '{-a.x, -a.y, -a.z};
            default: ;
         endcase
         add_tri(a, b, c);
      end
   endtask

   task automatic drain();
      while (pending_tris.size() > 0 || req_valid || expected_children.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_radius(input logic [30:0] value);
      @(posedge clock);
      csr_radius <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      radius_now = value;
      csr_valid <= 1'b0;
   endtask

   localparam logic signed [31:0] ONE = 32'sd65536;
   localparam logic signed [31:0] MAXV = 32'sh7fffffff;
   localparam logic signed [31:0] MINV = 32'sh80000000;

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed, reset radius, no idling
      add_tri('{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, ONE});
      add_tri('{-ONE, 0, 0}, '{0, -ONE, 0}, '{0, 0, -ONE});
      add_tri('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
      add_tri('{ONE, ONE, 0}, '{-ONE, -ONE, 0}, '{0, 0, ONE});
      add_tri('{MINV, MINV, MINV}, '{MINV, MINV, MINV}, '{MAXV, MAXV, MAXV});
      add_tri('{MAXV, MAXV, MAXV}, '{MAXV, MAXV, MAXV}, '{MINV, 0, MAXV});
      add_tri('{MINV, 0, 0}, '{MAXV, 0, 0}, '{0, 1, 0});
      add_tri('{1, 0, 0}, '{0, 0, 0}, '{-1, 0, 0});
      add_tri('{-1, -1, -1}, '{1, 1, 1}, '{ONE, -ONE, ONE});
      add_tri('{32'sd3, 0, 0}, '{0, 32'sd3, 0}, '{0, 0, 32'sd1});
      drain();

      write_radius(31'd0);
      add_tri('{ONE, 0, 0}, '{0, ONE, 0}, '{-ONE, 0, 0});
      add_random(5);
      drain();

      write_radius(31'h7fffffff);
      add_tri('{MINV, MINV, MINV}, '{MINV, MINV, MINV}, '{MAXV, MAXV, MAXV});
      add_tri('{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1});
      add_random(6);
      drain();

      write_radius(31'($urandom));
      snd_idle_pct = 70;
      add_random(6);
      drain();

      write_radius(31'($urandom_range(1 << 20)));
      snd_idle_pct = 0;
      rcv_idle_pct = 70;
      add_random(6);
      drain();

      // long hold-off while the sender keeps offering past the pipeline depth
      write_radius(RADIUS_RESET);
      rcv_idle_pct = 0;
      add_random(75);
      hold_start = 1'b1;
      drain();

      write_radius(31'($urandom));
      snd_idle_pct = 37;
      rcv_idle_pct = 37;
      add_random(10);
      drain();

      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
`default_nettype wire
